@@ design/single_wire_sensor_frame_decoder_macros.svh @@
// Assertion macros for the frame decoder's port-level checker.
// Each macro expects signals named clk and rst_n in the scope of use.
`ifndef SINGLE_WIRE_SENSOR_FRAME_DECODER_MACROS_SVH
`define SINGLE_WIRE_SENSOR_FRAME_DECODER_MACROS_SVH

// Same-cycle implication, checked out of reset
`define SWSFD_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("swsfd same-cycle check failed");

// Next-cycle implication, checked out of reset
`define SWSFD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("swsfd next-cycle check failed");

`endif

@@ design/swsfd_pkg.sv @@
// Shared types and constants of the single-wire sensor frame decoder.
// No dependencies; used by the channel interfaces, the top level and the checker.
package swsfd_pkg;

  typedef logic [1:0]  cmd_t;
  typedef logic [1:0]  status_t;
  typedef logic [5:0]  count_t;
  typedef logic [31:0] stamp_t;
  typedef logic [15:0] thresh_t;

  // Input commands
  localparam cmd_t CMD_START  = 2'd0;
  localparam cmd_t CMD_EDGE   = 2'd1;
  localparam cmd_t CMD_FINISH = 2'd2;

  // Result status codes
  localparam status_t STATUS_OK        = 2'd0;
  localparam status_t STATUS_CHECK_ERR = 2'd1;
  localparam status_t STATUS_NO_SENSOR = 2'd2;

  // Frame layout in edges
  localparam int FIRST_CHECK_EDGE = 34;
  localparam int LAST_DATA_SHIFT  = 33;
  localparam int LAST_CHECK_SHIFT = 41;
  localparam count_t FRAME_EDGES  = 6'd42;

  localparam thresh_t THRESH_RESET = 16'd100;

endpackage

@@ design/swsfd_if.sv @@
// Valid/ready channel interfaces for the frame decoder's input and result items.
// Depends on swsfd_pkg for payload types.
interface swsfd_in_if;
  logic                valid;
  logic                ready;
  swsfd_pkg::cmd_t     cmd;
  swsfd_pkg::stamp_t   edge_time_us;

  modport source (output valid, cmd, edge_time_us, input ready);
  modport sink   (input valid, cmd, edge_time_us, output ready);
endinterface

interface swsfd_out_if;
  logic                valid;
  logic                ready;
  swsfd_pkg::status_t  status;
  logic [15:0]         humidity_tenths;
  logic signed [15:0]  temperature_tenths;
  swsfd_pkg::count_t   edges_seen;

  modport source (output valid, status, humidity_tenths, temperature_tenths, edges_seen,
                  input ready);
  modport sink   (input valid, status, humidity_tenths, temperature_tenths, edges_seen,
                  output ready);
endinterface

@@ design/single_wire_sensor_frame_decoder.sv @@
// Top level of the single-wire sensor frame decoder: input register, frame state,
// bit decode and result register. Depends on swsfd_pkg and the interfaces in swsfd_if.sv.
//
//   channel | role   | carries
//   --------+--------+-------------------------------------------------------
//   in_ch   | sink   | cmd, edge_time_us
//   out_ch  | source | status, humidity_tenths, temperature_tenths, edges_seen
//   cfg_*   | sink   | bit_threshold_us write data, always ready
//
// One item per cycle unless a held result stalls; an accepted item passes from the input
// register through one subtract/compare stage into the result register when a frame ends.
// Reset (rst_n low, synchronous) clears the frame state and sets the threshold to 100.
// A held result stalls the input register only; in_ch stays ready while it is empty.
module single_wire_sensor_frame_decoder (
  input  logic                 clk,
  input  logic                 rst_n,
  swsfd_in_if.sink             in_ch,
  swsfd_out_if.source          out_ch,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  swsfd_pkg::thresh_t   cfg_data
);

  // Input register
  logic                s1_valid_r;
  swsfd_pkg::cmd_t     s1_cmd_r;
  swsfd_pkg::stamp_t   s1_time_r;

  // Frame state and threshold
  swsfd_pkg::count_t   count_r, count_nxt;
  logic [31:0]         data_r, data_nxt;
  logic [7:0]          check_r, check_nxt;
  swsfd_pkg::stamp_t   last_r, last_nxt;
  swsfd_pkg::thresh_t  thresh_r;

  // Result register
  logic                out_valid_r;
  swsfd_pkg::status_t  status_r, status_nxt;
  logic [15:0]         hum_r;
  logic [15:0]         temp_r;
  swsfd_pkg::count_t   seen_r;

  logic                out_free;
  logic                s1_go;
  logic                edge_act;
  logic                gap_bit;
  logic                fire;
  swsfd_pkg::stamp_t   gap;
  logic [7:0]          sum;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_ch.ready;
  assign s1_go     = s1_valid_r && out_free;
  assign in_ch.ready = !s1_valid_r || out_free;

  // Decode one item against the current frame
  always_comb begin
    gap      = s1_time_r - last_r;
    gap_bit  = gap > {16'd0, thresh_r};
    edge_act = (s1_cmd_r == swsfd_pkg::CMD_EDGE) && (count_r < swsfd_pkg::FRAME_EDGES);
    count_nxt = count_r;
    data_nxt  = data_r;
    check_nxt = check_r;
    last_nxt  = last_r;
    fire      = 1'b0;
    unique case (s1_cmd_r)
      swsfd_pkg::CMD_START: begin
        count_nxt = '0;
        data_nxt  = '0;
        check_nxt = '0;
        last_nxt  = '0;
      end
      swsfd_pkg::CMD_EDGE: begin
        if (edge_act) begin
          for (int i = 0; i < 32; i++) begin
            if (gap_bit && (count_r == 6'(swsfd_pkg::LAST_DATA_SHIFT - i))) begin
              data_nxt[i] = 1'b1;
            end
          end
          for (int j = 0; j < 8; j++) begin
            if (gap_bit && (count_r == 6'(swsfd_pkg::LAST_CHECK_SHIFT - j))) begin
              check_nxt[j] = 1'b1;
            end
          end
          count_nxt = count_r + 6'd1;
          last_nxt  = s1_time_r;
          fire      = (count_r + 6'd1) == swsfd_pkg::FRAME_EDGES;
        end
      end
      swsfd_pkg::CMD_FINISH: fire = 1'b1;
      default: ;
    endcase
    // Checksum over the updated word
    sum = data_nxt[7:0] + data_nxt[15:8] + data_nxt[23:16] + data_nxt[31:24];
    if (sum != check_nxt) begin
      status_nxt = swsfd_pkg::STATUS_CHECK_ERR;
    end else if (count_nxt == '0) begin
      status_nxt = swsfd_pkg::STATUS_NO_SENSOR;
    end else begin
      status_nxt = swsfd_pkg::STATUS_OK;
    end
  end

  // Capture input items and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      thresh_r   <= swsfd_pkg::THRESH_RESET;
    end else begin
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (cfg_valid) begin
        thresh_r <= cfg_data;
      end
    end
    if (in_ch.ready && in_ch.valid) begin
      s1_cmd_r  <= in_ch.cmd;
      s1_time_r <= in_ch.edge_time_us;
    end
  end

  // Advance frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      data_r  <= '0;
      check_r <= '0;
      last_r  <= '0;
    end else if (s1_go) begin
      count_r <= count_nxt;
      data_r  <= data_nxt;
      check_r <= check_nxt;
      last_r  <= last_nxt;
    end
  end

  // Hold or load the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r && fire;
    end
    if (s1_go && fire) begin
      status_r <= status_nxt;
      hum_r    <= data_nxt[31:16];
      temp_r   <= data_nxt[15:0];
      seen_r   <= count_nxt;
    end
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.status             = status_r;
  assign out_ch.humidity_tenths    = hum_r;
  assign out_ch.temperature_tenths = signed'(temp_r);
  assign out_ch.edges_seen         = seen_r;

endmodule

@@ design/swsfd_checker.sv @@
// Port-level checker for the frame decoder, bound to the top level.
// Depends on swsfd_pkg and single_wire_sensor_frame_decoder_macros.svh.
`include "single_wire_sensor_frame_decoder_macros.svh"

module swsfd_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input swsfd_pkg::status_t  out_status,
  input logic [15:0]         out_hum,
  input swsfd_pkg::count_t   out_seen
);

  // A stalled result keeps its payload
  `SWSFD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_hum) && $stable(out_seen) && $stable(out_status))

  // Never report more edges than a frame holds
  `SWSFD_ASSERT_SAME(a_seen_max, out_valid, out_seen <= swsfd_pkg::FRAME_EDGES)

  // No-sensor status only for an empty frame
  `SWSFD_ASSERT_SAME(a_nosensor_empty, out_valid && out_status == swsfd_pkg::STATUS_NO_SENSOR, out_seen == 6'd0)

  // An empty frame is cleared, so it always reads as no sensor
  `SWSFD_ASSERT_SAME(a_empty_nosensor, out_valid && out_seen == 6'd0, out_status == swsfd_pkg::STATUS_NO_SENSOR && out_hum == 16'd0)

endmodule

bind single_wire_sensor_frame_decoder swsfd_checker u_swsfd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_hum    (out_ch.humidity_tenths),
  .out_seen   (out_ch.edges_seen)
);

@@ verif/swsfd_frame_checker.sv @@
// Frame checker for the single-wire sensor frame decoder: watches the input, result and
// threshold channels, predicts each reading and compares it. Depends on swsfd_pkg and
// the channel interfaces in swsfd_if.sv.
module swsfd_frame_checker
  import swsfd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  swsfd_in_if     in_mon,
  swsfd_out_if    out_mon,
  input  logic    cfg_valid,
  input  logic    cfg_ready,
  input  thresh_t cfg_data,
  output int      mismatches,
  output int      pending_readings,
  output int      ok_readings,
  output int      sum_err_readings,
  output int      absent_readings
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_t            status;
    logic [15:0]        humidity;
    logic signed [15:0] temperature;
    count_t             edges;
  } reading_t;

  // Readings predicted but not yet seen on the result channel, oldest first
  reading_t expected_readings[$];

  // Predicted frame state and threshold
  thresh_t     bit_thresh;
  count_t      edge_cnt;
  stamp_t      word_bits;
  logic [7:0]  check_bits;
  stamp_t      prev_stamp;

  // Build the reading for the frame collected so far
  function automatic reading_t frame_reading();
    logic [7:0] byte_sum;
    reading_t   r;
    byte_sum = word_bits[31:24] + word_bits[23:16] + word_bits[15:8] + word_bits[7:0];
    if (byte_sum != check_bits) begin
      r.status = STATUS_CHECK_ERR;
    end else if (edge_cnt == '0) begin
      r.status = STATUS_NO_SENSOR;
    end else begin
      r.status = STATUS_OK;
    end
    r.humidity    = word_bits[31:16];
    r.temperature = word_bits[15:0];
    r.edges       = edge_cnt;
    return r;
  endfunction

  // Advance the frame state by one item and queue the reading it causes, if any
  task automatic decode_item(input cmd_t cmd, input stamp_t stamp);
    stamp_t gap;
    logic   bit_val;
    case (cmd)
      CMD_START: begin
        edge_cnt   = '0;
        word_bits  = '0;
        check_bits = '0;
        prev_stamp = '0;
      end
      CMD_FINISH: begin
        expected_readings.push_back(frame_reading());
      end
      CMD_EDGE: begin
        // Edges past a full frame are dropped without touching the timestamp
        if (edge_cnt < FRAME_EDGES) begin
          gap     = stamp - prev_stamp;
          bit_val = (gap > 32'(bit_thresh));
          if (edge_cnt >= FIRST_CHECK_EDGE) begin
            check_bits = check_bits | (8'(bit_val) << (LAST_CHECK_SHIFT - edge_cnt));
          end else if (edge_cnt > 1) begin
            word_bits = word_bits | (32'(bit_val) << (LAST_DATA_SHIFT - edge_cnt));
          end
          edge_cnt   = edge_cnt + 1'b1;
          prev_stamp = stamp;
          if (edge_cnt == FRAME_EDGES) begin
            expected_readings.push_back(frame_reading());
          end
        end
      end
      default: begin
        // unused command code: no effect
      end
    endcase
  endtask

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("reading field %s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Check results before predicting, so a reading is never matched to its own cycle's item
  always @(posedge clk) begin : monitor
    reading_t got;
    reading_t want;
    if (!rst_n) begin
      bit_thresh = THRESH_RESET;
      edge_cnt   = '0;
      word_bits  = '0;
      check_bits = '0;
      prev_stamp = '0;
      expected_readings.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got.status      = out_mon.status;
        got.humidity    = out_mon.humidity_tenths;
        got.temperature = out_mon.temperature_tenths;
        got.edges       = out_mon.edges_seen;
        if (expected_readings.size() == 0) begin
          $error("reading with none expected: status %0d, edges %0d", got.status, got.edges);
          mismatches++;
        end else begin
          want = expected_readings.pop_front();
          compare_field("status", want.status, got.status);
          compare_field("humidity_tenths", want.humidity, got.humidity);
          compare_field("temperature_tenths", want.temperature, got.temperature);
          compare_field("edges_seen", want.edges, got.edges);
          case (want.status)
            STATUS_OK:        ok_readings++;
            STATUS_CHECK_ERR: sum_err_readings++;
            default:          absent_readings++;
          endcase
        end
      end
      if (cfg_valid && cfg_ready) begin
        bit_thresh = cfg_data;
      end
      if (in_mon.valid && in_mon.ready) begin
        decode_item(in_mon.cmd, in_mon.edge_time_us);
      end
    end
    pending_readings = expected_readings.size();
  end

endmodule

@@ verif/tb_single_wire_sensor_frame_decoder.sv @@
// Top of the frame decoder testbench: clock, reset, item stimulus, result pacing and verdict.
// Depends on swsfd_pkg, swsfd_if.sv, the decoder RTL and swsfd_frame_checker.
module tb_single_wire_sensor_frame_decoder;
  timeunit 1ns;
  timeprecision 1ps;
  import swsfd_pkg::*;

  localparam cmd_t CMD_UNUSED      = 2'd3;
  localparam int   ITEMS_PER_PHASE = 315;
  localparam int   DRAIN_CYCLES    = 4;
  localparam int   END_CYCLES      = 8;
  localparam int   LONG_HOLD       = 400;
  localparam int   STALL_LIMIT     = 5000;
  localparam int   RESET_CYCLES    = 12;

  logic    clk = 1'b0;
  logic    rst_n;
  logic    cfg_valid;
  logic    cfg_ready;
  thresh_t cfg_data;

  int      sender_idle_pct;
  int      receiver_stall_pct;
  int      hold_requests;
  int      hold_served;
  int      hold_left;
  int      useful_items;
  int      idle_cycles;
  thresh_t active_thresh;
  thresh_t mid_thresh;
  stamp_t  now_us;

  int mismatches;
  int pending_readings;
  int ok_readings;
  int sum_err_readings;
  int absent_readings;

  swsfd_in_if  in_ch();
  swsfd_out_if out_ch();

  single_wire_sensor_frame_decoder u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  swsfd_frame_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .pending_readings(pending_readings),
    .ok_readings     (ok_readings),
    .sum_err_readings(sum_err_readings),
    .absent_readings (absent_readings)
  );

  always #5 clk = ~clk;

  // End the run when no channel moves an item for too long
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_single_wire_sensor_frame_decoder failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Pace the result channel; serve a long hold-off when one is requested
  initial begin : result_pacing
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left   = LONG_HOLD;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  // Offer one item, idling first at random; returns at the falling edge after acceptance
  task automatic send_item(input cmd_t cmd, input stamp_t stamp, input bit tally);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.cmd          <= cmd;
    in_ch.edge_time_us <= stamp;
    do @(posedge clk); while (!in_ch.ready);
    if (tally) useful_items++;
    @(negedge clk);
  endtask

  // Wait until every reading is in, then let in-flight items settle
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_readings != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_threshold(input thresh_t value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid     <= 1'b0;
    active_thresh = value;
  endtask

  // Edge gap that decodes to the wanted bit, hitting the threshold boundary now and then
  function automatic stamp_t gap_for(input logic one);
    if (one) begin
      return 32'(active_thresh) + (($urandom_range(7) == 0) ? 32'd1 : $urandom_range(1, 400));
    end
    return ($urandom_range(7) == 0) ? 32'(active_thresh) : $urandom_range(32'(active_thresh));
  endfunction

  // Send a sensor frame: optional start, edges that encode a word and check byte,
  // optional edges past the end and an optional finish
  task automatic send_frame(input bit with_start, input int n_edges, input bit good_sum,
                            input int extra_edges, input bit add_finish);
    stamp_t     word;
    logic [7:0] check;
    logic       bit_val;
    int         shape;
    shape = $urandom_range(9);
    word  = (shape == 0) ? '0 : (shape == 1) ? '1 : stamp_t'($urandom);
    check = word[31:24] + word[23:16] + word[15:8] + word[7:0];
    if (!good_sum) check = 8'($urandom);
    if (with_start) begin
      send_item(CMD_START, $urandom, 1'b1);
      now_us = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF - $urandom_range(3000) : $urandom;
    end
    for (int i = 0; i < n_edges + extra_edges; i++) begin
      if (!with_start || i < 2 || i >= FRAME_EDGES) begin
        bit_val = $urandom_range(1);
      end else if (i < FIRST_CHECK_EDGE) begin
        bit_val = word[LAST_DATA_SHIFT - i];
      end else begin
        bit_val = check[LAST_CHECK_SHIFT - i];
      end
      now_us += gap_for(bit_val);
      send_item(CMD_EDGE, now_us, i < FRAME_EDGES);
    end
    if (add_finish) send_item(CMD_FINISH, $urandom, 1'b1);
  endtask

  // Mostly full frames, otherwise cut-off frames, frames without a start or loose items
  task automatic random_scenario();
    int   pick;
    cmd_t cmd;
    pick = $urandom_range(99);
    if (pick < 60) begin
      send_frame(1'b1, FRAME_EDGES, $urandom_range(3) != 0,
                 ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0, $urandom_range(4) == 0);
    end else if (pick < 78) begin
      send_frame(1'b1, $urandom_range(FRAME_EDGES - 1), $urandom_range(1), 0, 1'b1);
    end else if (pick < 88) begin
      send_frame(1'b0, $urandom_range(1, 12), 1'b0, 0, $urandom_range(1));
    end else begin
      repeat ($urandom_range(1, 5)) begin
        cmd = cmd_t'($urandom_range(3));
        send_item(cmd, ($urandom_range(1) == 0) ? stamp_t'($urandom) : now_us + $urandom_range(500),
                  cmd != CMD_UNUSED);
      end
    end
  endtask

  initial begin : stimulus
    int phase_start;
    in_ch.valid        = 1'b0;
    in_ch.cmd          = CMD_START;
    in_ch.edge_time_us = '0;
    cfg_valid          = 1'b0;
    cfg_data           = '0;
    rst_n              = 1'b0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    active_thresh      = THRESH_RESET;
    now_us             = '0;
    mid_thresh         = 16'($urandom_range(1, 2000));
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty frame, unused code, wrap, threshold boundary, repeated finish
    send_item(CMD_FINISH, 32'h0000_0000, 1'b1);
    send_item(CMD_UNUSED, 32'hFFFF_FFFF, 1'b0);
    send_item(CMD_EDGE, 32'hFFFF_FFFF, 1'b1);
    send_item(CMD_EDGE, 32'd99, 1'b1);
    send_item(CMD_EDGE, 32'd199, 1'b1);
    send_item(CMD_EDGE, 32'd300, 1'b1);
    send_item(CMD_FINISH, $urandom, 1'b1);
    send_item(CMD_FINISH, $urandom, 1'b1);
    send_item(CMD_START, 32'hFFFF_FFFF, 1'b1);
    send_item(CMD_FINISH, 32'h0000_0000, 1'b1);

    // Random phases, each with its own pacing and threshold
    for (int p = 0; p < 4; p++) begin
      wait_drained();
      case (p)
        0: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 0;
          write_threshold(16'd0);
        end
        1: begin
          sender_idle_pct    = 60;
          receiver_stall_pct = 0;
          write_threshold(16'hFFFF);
        end
        2: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 60;
          write_threshold(mid_thresh);
        end
        default: begin
          sender_idle_pct    = 17;
          receiver_stall_pct = 17;
          write_threshold(THRESH_RESET);
        end
      endcase
      if (p == 0) begin
        // Hold the result side off and keep finishing so readings back up into the input
        @(posedge clk);
        hold_requests++;
        @(negedge clk);
        repeat (16) send_item(CMD_FINISH, $urandom, 1'b1);
      end
      phase_start = useful_items;
      while (useful_items - phase_start < ITEMS_PER_PHASE) random_scenario();
    end

    wait_drained();
    repeat (END_CYCLES) @(negedge clk);
    $display("Run covered %0d items across four pacing phases, thresholds 0, 65535, %0d, 100",
             useful_items, mid_thresh);
    $display("Readings checked: %0d good, %0d checksum errors, %0d without sensor",
             ok_readings, sum_err_readings, absent_readings);
    if (mismatches == 0 && pending_readings == 0) begin
      $display("tb_single_wire_sensor_frame_decoder passed");
    end else begin
      $display("tb_single_wire_sensor_frame_decoder failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+design
design/swsfd_pkg.sv
design/swsfd_if.sv
design/single_wire_sensor_frame_decoder.sv
design/swsfd_checker.sv
verif/swsfd_frame_checker.sv
verif/tb_single_wire_sensor_frame_decoder.sv
